>>> rtl/swm_pkg.sv
// Shared widths, defaults and inter-module types for the sliding window mean unit.
package swm_pkg;

    localparam int DATA_W         = 32;
    localparam int CFG_W          = 9;
    localparam int DEF_MAX_WINDOW = 256;
    localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET = 9'd20;

    // Divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } swm_div_stat_t;

endpackage

>>> rtl/swm_ring.sv
// Sample ring memory: one write port, one registered read port.
module swm_ring
    import swm_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WINDOW
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/swm_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module swm_divider
    import swm_pkg::*;
#(
    parameter int NUM_W = 40,
    parameter int DEN_W = 9
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic [NUM_W-1:0] quotient,
    output swm_div_stat_t    stat
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] div_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    always_comb begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        diff      = trial - {1'b0, div_reg};
        ge        = (trial >= {1'b0, div_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = CNT_W'(NUM_W);
        end else if (cnt_reg != '0) begin
            quo_next  = {quo_reg[NUM_W-2:0], ge};
            rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            div_reg <= divisor;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule

>>> rtl/sliding_window_mean_unit.sv
// Simple moving average over a configurable window of Q16.16 prices.
// Throughput: one item at a time. An item that completes no window passes through the
// update state and returns to idle; one that yields a mean also runs the bit-serial
// divider and then waits in the output state for the result register to drain.
// A result passes the update, divide and output states before it is registered as valid.
// Reset (aresetn, synchronous, active low) empties the window and sets window_length to 20.
module sliding_window_mean_unit
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [DATA_W-1:0] s_price,
    input  logic [DATA_W-1:0] s_time_tag,
    input  logic              s_start_series,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_average,
    output logic [DATA_W-1:0] m_result_tag
);

    localparam int IDX_W = $clog2(MAX_WINDOW);
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = DATA_W + IDX_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_UPDATE = 2'd1;
    localparam logic [1:0] ST_DIVIDE = 2'd2;
    localparam logic [1:0] ST_OUTPUT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CFG_W-1:0]  wlen_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]  wslot_reg, wslot_next;
    logic [IDX_W-1:0]  slot_reg;
    logic              full_reg, emit_reg;
    logic [DATA_W-1:0] price_reg, tag_reg;
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_average_reg, m_result_tag_reg;

    logic [LEN_W-1:0]  eff_len;
    logic              s_xfer;
    logic              m_load;
    logic [SUM_W-1:0]  sum_base;
    logic [LEN_W-1:0]  fill_base;
    logic [IDX_W-1:0]  slot_acc;
    logic [LEN_W-1:0]  slot_inc;
    logic              full_acc;

    logic [DATA_W-1:0] ring_rd_data;
    logic              div_start;
    logic [SUM_W-1:0]  div_quotient;
    swm_div_stat_t     div_stat;

    // Window length clamped to 1..MAX_WINDOW
    always_comb begin
        if (wlen_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (32'(wlen_reg) > MAX_WINDOW) begin
            eff_len = LEN_W'(MAX_WINDOW);
        end else begin
            eff_len = LEN_W'(wlen_reg);
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign s_xfer  = s_valid && s_ready;
    assign m_load  = (state_reg == ST_OUTPUT) && (!m_valid_reg || m_ready);

    // Bookkeeping at input transfer; a new series starts from an empty window
    always_comb begin
        sum_base  = s_start_series ? '0 : sum_reg;
        fill_base = s_start_series ? '0 : fill_reg;
        slot_acc  = s_start_series ? '0 : wslot_reg;
        if (LEN_W'(slot_acc) >= eff_len) begin
            slot_acc = '0;
        end
        full_acc  = (fill_base >= eff_len);
        slot_inc  = LEN_W'(slot_acc) + 1'b1;
    end

    always_comb begin
        state_next = state_reg;
        sum_next   = sum_reg;
        fill_next  = fill_reg;
        wslot_next = wslot_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    sum_next   = sum_base + SUM_W'(s_price);
                    fill_next  = full_acc ? fill_base : fill_base + 1'b1;
                    wslot_next = (slot_inc == eff_len) ? '0 : slot_inc[IDX_W-1:0];
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // oldest sample leaves the sum once the window is full
                sum_next = sum_reg - (full_reg ? SUM_W'(ring_rd_data) : '0);
                if (emit_reg) begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE: begin
                if (div_stat.done) begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                if (m_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_we) begin
            sum_next   = '0;
            fill_next  = '0;
            wslot_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wlen_reg    <= WINDOW_LENGTH_RESET;
            sum_reg     <= '0;
            fill_reg    <= '0;
            wslot_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            fill_reg  <= fill_next;
            wslot_reg <= wslot_next;
            if (cfg_we) begin
                wlen_reg <= cfg_wdata;
            end
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            price_reg <= s_price;
            tag_reg   <= s_time_tag;
            slot_reg  <= slot_acc;
            full_reg  <= full_acc;
            emit_reg  <= full_acc || ((fill_base + 1'b1) >= eff_len);
        end
        if (m_load) begin
            m_average_reg    <= div_quotient[DATA_W-1:0];
            m_result_tag_reg <= tag_reg;
        end
    end

    swm_ring #(
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .rd_en   (s_xfer),
        .rd_addr (slot_acc),
        .rd_data (ring_rd_data),
        .wr_en   (state_reg == ST_UPDATE),
        .wr_addr (slot_reg),
        .wr_data (price_reg)
    );

    swm_divider #(
        .NUM_W (SUM_W),
        .DEN_W (LEN_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (eff_len),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    assign m_valid      = m_valid_reg;
    assign m_average    = m_average_reg;
    assign m_result_tag = m_result_tag_reg;

endmodule

>>> rtl/swm_checker.sv
// Port-level checks for the sliding window mean unit, bound to the top level.
module swm_port_checker
    import swm_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              cfg_we,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [DATA_W-1:0] m_average,
    input logic [DATA_W-1:0] m_result_tag
);

    // no result is pending right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_average) && $stable(m_result_tag))
        else $error("result changed while stalled");

    // one item at a time: busy for at least the update cycle after a transfer
    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after transfer");

    // a config write on an idle block does not start any work
    a_cfg_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we && s_ready && !s_valid |=> s_ready)
        else $error("config write made block busy");

endmodule

bind sliding_window_mean_unit swm_port_checker u_swm_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .cfg_we       (cfg_we),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_average    (m_average),
    .m_result_tag (m_result_tag)
);

>>> dv/swm_checker.sv
// Checker for the sliding window mean unit: tracks the price window and compares each mean.
module swm_checker
    import swm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [DATA_W-1:0] s_price,
    input  logic [DATA_W-1:0] s_time_tag,
    input  logic              s_start_series,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [DATA_W-1:0] m_average,
    input  logic [DATA_W-1:0] m_result_tag,
    output int                mismatch_count,
    output int                results_due
);

    typedef struct packed {
        logic [DATA_W-1:0] average;
        logic [DATA_W-1:0] tag;
    } mean_entry_t;

    logic [DATA_W-1:0] price_ring [DEF_MAX_WINDOW];
    logic [39:0]       running_sum;
    int unsigned       fill_count;
    int unsigned       next_slot;
    logic [CFG_W-1:0]  window_reg;
    mean_entry_t       pending_means [$];
    mean_entry_t       want;

    task automatic empty_window();
        running_sum = '0;
        fill_count  = 0;
        next_slot   = 0;
    endtask

    // One price in: swap it for the oldest sample once full, queue the mean when the window is complete
    task automatic advance_window(input logic [DATA_W-1:0] price,
                                  input logic [DATA_W-1:0] tag,
                                  input logic restart);
        int unsigned span;
        int unsigned slot;
        mean_entry_t mean;
        span = (window_reg == 0) ? 1 :
               (window_reg > DEF_MAX_WINDOW) ? DEF_MAX_WINDOW : window_reg;
        if (restart) empty_window();
        slot = (next_slot >= span) ? 0 : next_slot;
        if (fill_count >= span) begin
            running_sum -= price_ring[slot];
        end else begin
            fill_count++;
        end
        price_ring[slot] = price;
        running_sum += price;
        next_slot = (slot + 1 >= span) ? 0 : slot + 1;
        if (fill_count >= span) begin
            mean.average = DATA_W'(running_sum / span);
            mean.tag     = tag;
            pending_means.insert(pending_means.size(), mean);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            window_reg = WINDOW_LENGTH_RESET;
            empty_window();
            pending_means.delete();
            mismatch_count = 0;
        end else begin
            // a length write also empties the window
            if (cfg_we) begin
                window_reg = cfg_wdata;
                empty_window();
            end
            if (m_valid && m_ready) begin
                if (pending_means.size() == 0) begin
                    $error("unexpected mean transfer: average %h result_tag %h",
                           m_average, m_result_tag);
                    mismatch_count++;
                end else begin
                    want = pending_means.pop_front();
                    if (m_average !== want.average) begin
                        $error("average: expected %h, got %h", want.average, m_average);
                        mismatch_count++;
                    end
                    if (m_result_tag !== want.tag) begin
                        $error("result_tag: expected %h, got %h", want.tag, m_result_tag);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) advance_window(s_price, s_time_tag, s_start_series);
        end
        results_due = pending_means.size();
    end

endmodule

>>> dv/tb_top.sv
// Top-level bench for the sliding window mean unit: stimulus, flow control and verdict.
module tb_top;
    import swm_pkg::*;

    localparam int RANDOM_ITEMS  = 1850;
    localparam int SETTLE_CYCLES = 64;    // outlasts the divider on the last transfer
    localparam int STALL_LIMIT   = 1000;  // outlasts the longest legal quiet stretch

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_we;
    logic [CFG_W-1:0]  cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    logic [DATA_W-1:0] s_price;
    logic [DATA_W-1:0] s_time_tag;
    logic              s_start_series;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [DATA_W-1:0] m_average;
    logic [DATA_W-1:0] m_result_tag;

    int   mismatch_count;
    int   results_due;
    bit   no_idle_phase = 1'b0;
    logic m_taken = 1'b0;
    int   ready_hold;
    int   stall_cycles;

    always #5 aclk = ~aclk;

    sliding_window_mean_unit uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_price        (s_price),
        .s_time_tag     (s_time_tag),
        .s_start_series (s_start_series),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_average      (m_average),
        .m_result_tag   (m_result_tag)
    );

    swm_checker mean_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_price        (s_price),
        .s_time_tag     (s_time_tag),
        .s_start_series (s_start_series),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_average      (m_average),
        .m_result_tag   (m_result_tag),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    function automatic int draw_wait();
        return no_idle_phase ? 0 : $urandom_range(0, 4);
    endfunction

    // entered and left at a falling edge
    task automatic send_sample(input logic [DATA_W-1:0] price,
                               input logic [DATA_W-1:0] tag,
                               input logic restart);
        int gap;
        gap = draw_wait();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_price        <= price;
        s_time_tag     <= tag;
        s_start_series <= restart;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic await_drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (results_due != 0) @(negedge aclk);
    endtask

    task automatic program_window(input logic [CFG_W-1:0] win);
        await_drain();
        // a transfer that completes no window may still be in flight
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= win;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: each mean draws a stall, applied while it is actually waiting
    always @(posedge aclk) m_taken <= m_valid && m_ready;

    initial begin
        ready_hold = draw_wait();
        forever begin
            @(negedge aclk);
            if (m_taken) ready_hold = draw_wait();
            if (ready_hold != 0) begin
                m_ready <= 1'b0;
                if (m_valid) ready_hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        stall_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        int                random_sent;
        int                phase;
        int                span;
        int                phase_items;
        int                pick;
        logic [CFG_W-1:0]  win;
        logic [DATA_W-1:0] price;

        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_price        = '0;
        s_time_tag     = '0;
        s_start_series = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset length of 20: full-scale prices fill the window, then a zero slides in
        for (int i = 0; i < 20; i++) send_sample('1, DATA_W'(i), i == 0);
        send_sample('0, '1, 1'b0);

        // zero length behaves as one
        program_window('0);
        send_sample('0, '0, 1'b1);
        send_sample('1, 32'hA5A5_5A5A, 1'b0);

        // length two: max sum, then a restart with a half-filled window
        program_window(9'd2);
        send_sample('1, 32'd1, 1'b0);
        send_sample('1, 32'd2, 1'b0);
        send_sample(32'd5, 32'd3, 1'b1);
        send_sample(32'd8, 32'd4, 1'b0);

        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case (phase)
                0: begin
                    win = 9'h1FF;  // saturates to the full ring
                end
                1: begin
                    win = 9'd1;
                end
                2: begin
                    win = 9'd256;
                end
                default: begin
                    pick = $urandom_range(0, 19);
                    if (pick < 14) begin
                        win = CFG_W'($urandom_range(1, 16));
                    end else if (pick < 19) begin
                        win = CFG_W'($urandom_range(17, 64));
                    end else begin
                        win = CFG_W'($urandom_range(0, 300));
                    end
                end
            endcase
            span = (win == 0) ? 1 : (win > DEF_MAX_WINDOW) ? DEF_MAX_WINDOW : win;
            no_idle_phase = ($urandom_range(0, 3) == 0);
            program_window(win);
            phase_items = span + $urandom_range(8, 48);
            for (int n = 0; n < phase_items; n++) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    price = '0;
                end else if (pick == 1) begin
                    price = '1;
                end else if (pick == 2) begin
                    price = DATA_W'($urandom_range(0, 255)) << 16;
                end else begin
                    price = DATA_W'($urandom);
                end
                send_sample(price, DATA_W'($urandom), $urandom_range(0, 39) == 0);
                if ($urandom_range(0, 49) == 0) await_drain();
            end
            random_sent += phase_items;
            phase++;
        end

        await_drain();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && results_due == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/swm_pkg.sv
rtl/swm_ring.sv
rtl/swm_divider.sv
rtl/sliding_window_mean_unit.sv
rtl/swm_checker.sv
dv/swm_checker.sv
dv/tb_top.sv
